FILE: sv/spgd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spgd_pkg;

	localparam int CHANNELS_DEF = 4;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [15:0] GAIN_RST = 16'd1280;
	localparam logic [14:0] PSCALE_RST = 15'd1311;
	localparam logic [15:0] MSCALE_RST = 16'd4096;
	localparam logic [14:0] LOWER_RST = 15'd1638;
	localparam logic [14:0] UPPER_RST = 15'd31129;
	localparam logic [14:0] RECENTER_RST = 15'd16384;
	localparam logic [15:0] SEED_RST = 16'd44257;

	localparam logic [14:0] TWO_VOLT_CODES = 15'd6554;
	localparam logic [15:0] LFSR_TAPS = 16'hB400;

	typedef enum logic [1:0] {
		PH_NOMINAL = 2'd0,
		PH_PLUS = 2'd1,
		PH_MINUS = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		REG_GAIN = 3'd0,
		REG_PSCALE = 3'd1,
		REG_MSCALE = 3'd2,
		REG_LOWER = 3'd3,
		REG_UPPER = 3'd4,
		REG_RECENTER = 3'd5,
		REG_SEED = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] gain;
		logic [14:0] pscale;
		logic [15:0] mscale;
		logic [14:0] lower;
		logic [14:0] upper;
		logic [14:0] recenter;
		logic [15:0] seed;
		logic seed_load;
	} cfg_t;

	function automatic logic [15:0] lfsr_step(input logic [15:0] s);
		logic [15:0] n;
		n = {1'b0, s[15:1]};
		if (s[0]) begin
			n = n ^ LFSR_TAPS;
		end
		if (n == 16'd0) begin
			n = 16'd1;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

FILE: sv/spgd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module spgd_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: sv/spgd_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module spgd_regs import spgd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [ADDR_W-1:0] paddr,
	input wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready,
	output cfg_t cfg
);

	logic [15:0] gain_q;
	logic [14:0] pscale_q;
	logic [15:0] mscale_q;
	logic [14:0] lower_q;
	logic [14:0] upper_q;
	logic [14:0] recenter_q;
	logic [15:0] seed_q;
	logic wr;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RST;
			pscale_q <= PSCALE_RST;
			mscale_q <= MSCALE_RST;
			lower_q <= LOWER_RST;
			upper_q <= UPPER_RST;
			recenter_q <= RECENTER_RST;
			seed_q <= SEED_RST;
		end else if (wr) begin
			case (idx)
				REG_GAIN: gain_q <= pwdata[15:0];
				REG_PSCALE: pscale_q <= pwdata[14:0];
				REG_MSCALE: mscale_q <= pwdata[15:0];
				REG_LOWER: lower_q <= pwdata[14:0];
				REG_UPPER: upper_q <= pwdata[14:0];
				REG_RECENTER: recenter_q <= pwdata[14:0];
				REG_SEED: seed_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_GAIN: prdata = DATA_W'(gain_q);
			REG_PSCALE: prdata = DATA_W'(pscale_q);
			REG_MSCALE: prdata = DATA_W'(mscale_q);
			REG_LOWER: prdata = DATA_W'(lower_q);
			REG_UPPER: prdata = DATA_W'(upper_q);
			REG_RECENTER: prdata = DATA_W'(recenter_q);
			REG_SEED: prdata = DATA_W'(seed_q);
			default: prdata = '0;
		endcase
	end

	always_comb begin
		cfg.gain = gain_q;
		cfg.pscale = pscale_q;
		cfg.mscale = mscale_q;
		cfg.lower = lower_q;
		cfg.upper = upper_q;
		cfg.recenter = recenter_q;
		cfg.seed = pwdata[15:0];
		cfg.seed_load = wr && (idx == REG_SEED);
	end

endmodule

`default_nettype wire

FILE: sv/spgd_core.sv
`timescale 1ns / 1ps
`default_nettype none

module spgd_core import spgd_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire cfg_t cfg,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic signed [15:0] metric,
	output logic out_valid,
	input wire logic out_ready,
	output logic [5:0] channel,
	output logic [14:0] drive,
	output logic [1:0] phase_out,
	output logic last
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_MUL = 8'b00000010,
		S_SCALE = 8'b00000100,
		S_GAIN = 8'b00001000,
		S_READ = 8'b00010000,
		S_CALC = 8'b00100000,
		S_STEP = 8'b01000000,
		S_WB = 8'b10000000
	} state_t;

	typedef enum logic [1:0] {
		OP_INIT = 2'd0,
		OP_PERT = 2'd1,
		OP_MINUS = 2'd2,
		OP_UPDATE = 2'd3
	} op_t;

	state_t state_q;
	op_t op_q;
	op_t op_new;
	phase_t phase_q;
	phase_t res_phase;
	logic started_q;
	logic [15:0] lfsr_q;
	logic [15:0] lfsr_nx;
	logic [CH_W-1:0] ch_q;
	logic ch_last;

	logic signed [15:0] metric_q;
	logic signed [32:0] msc_s1;
	logic signed [33:0] msc_rnd;
	logic signed [21:0] msc_sh;
	logic signed [15:0] scaled;
	logic signed [15:0] plus_q;
	logic signed [16:0] diff_q;
	logic signed [32:0] gd_q;

	logic [14:0] rnd_mul;
	logic [30:0] rnd_prod;
	logic [14:0] rnd_q;
	logic [14:0] v_q;
	logic [14:0] dv_q;
	logic signed [47:0] p_q;
	logic signed [51:0] x10;
	logic signed [28:0] step_q;
	logic signed [29:0] nv;
	logic [15:0] psum;
	logic [14:0] res;
	logic [14:0] new_v;
	logic out_free;
	logic advance;

	logic [29:0] rdata;
	logic [14:0] rd_v;
	logic [14:0] rd_dv;

	logic out_valid_q;
	logic [CH_W-1:0] out_ch_q;
	logic [14:0] out_drive_q;
	phase_t out_phase_q;
	logic out_last_q;

	spgd_ram #(
		.WIDTH(30),
		.DEPTH(CHANNELS)
	) u_ram (
		.clk(clk),
		.we(advance),
		.waddr(ch_q),
		.wdata({new_v, dv_q}),
		.raddr(ch_q),
		.rdata(rdata)
	);

	assign rd_v = rdata[29:15];
	assign rd_dv = rdata[14:0];
	assign in_ready = (state_q == S_IDLE);
	assign ch_last = (ch_q == CH_W'(CHANNELS - 1));
	assign out_free = !out_valid_q || out_ready;
	assign advance = (state_q == S_WB) && out_free;
	assign lfsr_nx = lfsr_step(lfsr_q);

	always_comb begin
		if (!started_q) begin
			op_new = OP_INIT;
		end else begin
			case (phase_q)
				PH_PLUS: op_new = OP_MINUS;
				PH_MINUS: op_new = OP_UPDATE;
				default: op_new = OP_PERT;
			endcase
		end
	end

	// metric scaling, ties toward +inf then saturate
	always_comb begin
		msc_rnd = 34'(msc_s1) + 34'sd2048;
		msc_sh = msc_rnd[33:12];
		if (msc_sh > 22'sd32767) begin
			scaled = 16'sh7FFF;
		end else if (msc_sh < -22'sd32768) begin
			scaled = -16'sd32768;
		end else begin
			scaled = msc_sh[15:0];
		end
	end

	assign rnd_mul = (op_q == OP_INIT) ? TWO_VOLT_CODES : cfg.pscale;
	assign rnd_prod = 31'(lfsr_nx) * 31'(rnd_mul);
	assign x10 = (52'(p_q) <<< 3) + (52'(p_q) <<< 1) + 52'sd4194304;
	assign nv = $signed({15'd0, v_q}) + 30'(step_q);
	assign psum = {1'b0, v_q} + {1'b0, dv_q};

	always_comb begin
		new_v = v_q;
		case (op_q)
			OP_INIT: begin
				res = v_q;
				res_phase = PH_NOMINAL;
			end
			OP_PERT: begin
				res = psum[15] ? 15'h7FFF : psum[14:0];
				res_phase = PH_PLUS;
			end
			OP_MINUS: begin
				res = (v_q > dv_q) ? (v_q - dv_q) : 15'd0;
				res_phase = PH_MINUS;
			end
			default: begin
				if (nv < $signed({15'd0, cfg.lower}) || nv > $signed({15'd0, cfg.upper})) begin
					new_v = cfg.recenter;
				end else begin
					new_v = nv[14:0];
				end
				res = new_v;
				res_phase = PH_NOMINAL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_INIT;
			phase_q <= PH_NOMINAL;
			started_q <= 1'b0;
			lfsr_q <= SEED_RST;
			ch_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.seed_load) begin
				lfsr_q <= (cfg.seed == 16'd0) ? 16'd1 : cfg.seed;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q <= op_new;
						ch_q <= '0;
						if (op_new == OP_MINUS || op_new == OP_UPDATE) begin
							state_q <= S_MUL;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_MUL: state_q <= S_SCALE;
				S_SCALE: state_q <= S_GAIN;
				S_GAIN: state_q <= S_READ;
				S_READ: begin
					if (op_q == OP_INIT || op_q == OP_PERT) begin
						lfsr_q <= lfsr_nx;
					end
					state_q <= S_CALC;
				end
				S_CALC: state_q <= S_STEP;
				S_STEP: state_q <= S_WB;
				S_WB: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (ch_last) begin
							state_q <= S_IDLE;
							started_q <= 1'b1;
							phase_q <= res_phase;
							ch_q <= '0;
						end else begin
							ch_q <= ch_q + 1'b1;
							state_q <= S_READ;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			metric_q <= metric;
		end
		if (state_q == S_MUL) begin
			msc_s1 <= metric_q * $signed({1'b0, cfg.mscale});
		end
		if (state_q == S_SCALE) begin
			if (op_q == OP_MINUS) begin
				plus_q <= scaled;
			end
			diff_q <= 17'(plus_q) - 17'(scaled);
		end
		if (state_q == S_GAIN) begin
			gd_q <= diff_q * $signed({1'b0, cfg.gain});
		end
		if (state_q == S_READ) begin
			rnd_q <= rnd_prod[30:16];
		end
		if (state_q == S_CALC) begin
			v_q <= (op_q == OP_INIT) ? rnd_q : rd_v;
			dv_q <= (op_q == OP_PERT) ? rnd_q : rd_dv;
			p_q <= gd_q * $signed({1'b0, rd_dv});
		end
		if (state_q == S_STEP) begin
			step_q <= x10[51:23];
		end
		if (advance) begin
			out_ch_q <= ch_q;
			out_drive_q <= res;
			out_phase_q <= res_phase;
			out_last_q <= ch_last;
		end
	end

	assign out_valid = out_valid_q;
	assign channel = 6'(out_ch_q);
	assign drive = out_drive_q;
	assign phase_out = out_phase_q;
	assign last = out_last_q;

endmodule

`default_nettype wire

FILE: sv/spgd_dither_optimizer_top.sv
// an item that carries a metric (minus and update phases) passes the mul, scale and gain states,
// one that does not (first item, plus phase) skips them; a new item is accepted only in idle
// channels are served one at a time through the read and write ports of the state memory
// each result passes read, calc, step and writeback; writeback waits while the output is stalled
// async reset sets control, configuration registers and lfsr; drive and perturbation memory is not cleared
`timescale 1ns / 1ps
`default_nettype none

module spgd_dither_optimizer_top import spgd_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [ADDR_W-1:0] paddr,
	input wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic signed [15:0] metric,
	output logic out_valid,
	input wire logic out_ready,
	output logic [5:0] channel,
	output logic [14:0] drive,
	output logic [1:0] phase_out,
	output logic last
);

	cfg_t cfg;

	spgd_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	spgd_core #(
		.CHANNELS(CHANNELS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.metric(metric),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.channel(channel),
		.drive(drive),
		.phase_out(phase_out),
		.last(last)
	);

endmodule

`default_nettype wire

FILE: sv/spgd_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module spgd_chk import spgd_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [5:0] channel,
	input wire logic [14:0] drive,
	input wire logic [1:0] phase_out,
	input wire logic last
);

	localparam logic [5:0] CH_LAST = 6'(CHANNELS - 1);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(channel) && $stable(drive)
			&& $stable(phase_out) && $stable(last))
		else $error("result changed while stalled");

	a_phase_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> phase_out == PH_NOMINAL || phase_out == PH_PLUS
			|| phase_out == PH_MINUS)
		else $error("bad phase code");

	a_last_chan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (channel == CH_LAST)) && (channel <= CH_LAST))
		else $error("last flag does not match channel");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a second transaction while busy");

endmodule

bind spgd_dither_optimizer_top spgd_chk #(
	.CHANNELS(CHANNELS)
) u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.channel(channel),
	.drive(drive),
	.phase_out(phase_out),
	.last(last)
);

`default_nettype wire
